// ----- hdl/fsp_pkg.sv -----
// Shared types and constants for the five-point stencil matrix-vector block.
// No dependencies.
`default_nettype none
package fsp_pkg;

    localparam int VAL_W   = 32;
    localparam int PROD_W  = 48;
    localparam int QDEPTH  = 4;
    localparam int QCNT_W  = 3;
    localparam int HALF_LSB = 32768;   // half of one Q.28 step at Q.44

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // input kinds carried in tuser
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // one result job: five values and five coefficients, disabled terms zeroed
    typedef struct packed {
        logic signed [VAL_W-1:0] val_c;
        logic signed [VAL_W-1:0] val_l;
        logic signed [VAL_W-1:0] val_r;
        logic signed [VAL_W-1:0] val_u;
        logic signed [VAL_W-1:0] val_d;
        logic signed [VAL_W-1:0] co_c;
        logic signed [VAL_W-1:0] co_l;
        logic signed [VAL_W-1:0] co_r;
        logic signed [VAL_W-1:0] co_u;
        logic signed [VAL_W-1:0] co_d;
        logic                    last;
    } job_t;

endpackage
`default_nettype wire

// ----- hdl/five_point_stencil_matvec.sv -----
// Top level of the five-point stencil matrix-vector block.
// Depends on fsp_pkg, fsp_front, fsp_queue, fsp_back.
//
// channel  dir  tdata                                         tuser      tlast
// s_*      in   point_value,diag,left,right,up,down (192b)    operation  -
// m_*      out  product_value (48b)                           saturated  last_point
// cfg_*    in   write: 0 = grid_width, 1 = grid_height        -          -
//
// One transaction per clock while s_tready is high; the point completing a result
// passes through store read at acceptance, queue write, multiply, two add stages
// and the output register before m_tvalid rises.
// Value store read at two addresses and coefficient store at one per item.
// Reset clears counters, valid bits and the grid size registers only; no clearing pass.
// s_tready falls when the 4-deep job queue plus the job in the store-read stage
// would leave no room.
`default_nettype none
module five_point_stencil_matvec #(
    parameter int MAX_GRID_WIDTH = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [191:0]  s_tdata,   // point_value, diag, left, right, up, down
    input  wire logic          s_tuser,   // operation
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,   // product_value
    output logic               m_tuser,   // saturated
    output logic               m_tlast,
    input  wire logic          cfg_we,
    input  wire logic          cfg_addr,
    input  wire logic [8:0]    cfg_wdata
);
    import fsp_pkg::*;

    job_t              push_job, pop_job;
    logic              q_push, q_pop, q_not_empty;
    logic [QCNT_W-1:0] q_fill;

    fsp_front #(.MAX_GRID_WIDTH(MAX_GRID_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .q_fill(q_fill), .q_push(q_push), .q_entry(push_job)
    );

    fsp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .wr_job(push_job), .pop(q_pop), .rd_job(pop_job),
        .not_empty(q_not_empty), .fill(q_fill)
    );

    fsp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job(pop_job), .job_valid(q_not_empty), .pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |-> 32'(q_fill) < QDEPTH)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("job queue underflow");
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        32'(q_fill) == QDEPTH |-> !s_tready)
        else $error("input accepted with full queue");
`endif

endmodule
`default_nettype wire

// ----- hdl/fsp_front.sv -----
// Front end: accepts transactions, tracks grid position, holds line stores
// and builds result jobs. Depends on fsp_pkg.
`default_nettype none
module fsp_front #(
    parameter int MAX_GRID_WIDTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [191:0]      s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              cfg_we,
    input  wire logic              cfg_addr,
    input  wire logic [8:0]        cfg_wdata,
    input  wire logic [fsp_pkg::QCNT_W-1:0] q_fill,
    output logic                   q_push,
    output fsp_pkg::job_t          q_entry
);
    import fsp_pkg::*;

    localparam int VSLOTS = 2 * MAX_GRID_WIDTH;
    localparam int AW = $clog2(VSLOTS);
    localparam int CW = $clog2(MAX_GRID_WIDTH);

    logic [8:0]  width_reg, height_reg;
    logic [8:0]  w, h;
    logic [16:0] total;

    logic [16:0] rcv_reg, rcv_next, emt_reg, emt_next;
    logic [8:0]  rcol_reg, rcol_next, rrow_reg, rrow_next;
    logic [8:0]  ecol_reg, ecol_next, erow_reg, erow_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cp_reg, cp_next;

    logic          acc, shift, res, is_data, last_p;
    logic [8:0]    pcol, prow;
    logic [16:0]   pnum;
    int            ra_i, ru_i, rc_i;
    logic [AW-1:0] ra, ru;
    logic [CW-1:0] rc;

    logic [VAL_W-1:0]   vmem [VSLOTS];
    logic [159:0]       cmem [MAX_GRID_WIDTH];
    logic [VAL_W-1:0]   rd_a_reg, rd_u_reg, win_m_reg, win_l_reg, cur_reg;
    logic [159:0]       rd_c_reg;

    logic s1_shift_reg, s1_res_reg, s1_last_reg;
    logic [3:0] s1_en_reg;   // left, right, up, down

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_GRID_WIDTH)
                width_reg <= cfg_wdata;
            else
                height_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (width_reg < 9'd2)
            w = 9'd2;
        else if (32'(width_reg) > MAX_GRID_WIDTH)
            w = 9'(MAX_GRID_WIDTH);
        else
            w = width_reg;
        if (height_reg < 9'd2)
            h = 9'd2;
        else if (height_reg > 9'd256)
            h = 9'd256;
        else
            h = height_reg;
        total = 17'(w) * 17'(h);
    end

    // at most one job in stage 1 besides the queue contents
    assign s_tready = (32'(q_fill) + 32'(s1_res_reg)) < QDEPTH;
    assign acc      = s_tvalid && s_tready;
    assign is_data  = (s_tuser == OP_DATA);

    always_comb
    begin
        rcv_next  = rcv_reg;
        emt_next  = emt_reg;
        rcol_next = rcol_reg;
        rrow_next = rrow_reg;
        ecol_next = ecol_reg;
        erow_next = erow_reg;
        shift     = 1'b0;
        res       = 1'b0;
        pcol      = ecol_reg;
        prow      = erow_reg;
        pnum      = emt_reg;
        if (acc)
        begin
            if (is_data)
            begin
                if (rcv_reg < total)
                begin
                    shift    = 1'b1;
                    rcv_next = rcv_reg + 17'd1;
                    if (rcol_reg == w - 9'd1)
                    begin
                        rcol_next = '0;
                        rrow_next = rrow_reg + 9'd1;
                    end
                    else
                        rcol_next = rcol_reg + 9'd1;
                    if (rcv_reg >= 17'(w))
                    begin
                        res      = 1'b1;
                        pcol     = rcol_reg;
                        prow     = rrow_reg - 9'd1;
                        pnum     = rcv_reg - 17'(w);
                        emt_next = pnum + 17'd1;
                        if (rcol_reg == w - 9'd1)
                        begin
                            ecol_next = '0;
                            erow_next = rrow_reg;
                        end
                        else
                        begin
                            ecol_next = rcol_reg + 9'd1;
                            erow_next = rrow_reg - 9'd1;
                        end
                    end
                end
            end
            else if (rcv_reg >= total)
            begin
                if (emt_reg >= total)
                begin
                    rcv_next = '0; emt_next = '0;
                    rcol_next = '0; rrow_next = '0;
                    ecol_next = '0; erow_next = '0;
                end
                else
                begin
                    shift = 1'b1;
                    res   = 1'b1;
                    emt_next = emt_reg + 17'd1;
                    if (ecol_reg == w - 9'd1)
                    begin
                        ecol_next = '0;
                        erow_next = erow_reg + 9'd1;
                    end
                    else
                        ecol_next = ecol_reg + 9'd1;
                    if (emt_reg + 17'd1 >= total)
                    begin
                        rcv_next = '0; emt_next = '0;
                        rcol_next = '0; rrow_next = '0;
                        ecol_next = '0; erow_next = '0;
                    end
                end
            end
        end
        last_p = (pnum == total - 17'd1);
        // ring pointers advance on every counted item, drains included
        wp_next = shift ? ((32'(wp_reg) == VSLOTS - 1) ? '0 : wp_reg + 1'b1) : wp_reg;
        cp_next = shift ? ((32'(cp_reg) == MAX_GRID_WIDTH - 1) ? '0 : cp_reg + 1'b1)
                        : cp_reg;
        // reads of point p+1, p-w and the coefficients of p
        ra_i = int'(wp_reg) + 1 - int'(w);
        if (ra_i < 0)
            ra_i = ra_i + VSLOTS;
        ru_i = int'(wp_reg) - 2 * int'(w);
        if (ru_i < 0)
            ru_i = ru_i + VSLOTS;
        rc_i = int'(cp_reg) - int'(w);
        if (rc_i < 0)
            rc_i = rc_i + MAX_GRID_WIDTH;
        ra = AW'(ra_i);
        ru = AW'(ru_i);
        rc = CW'(rc_i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_reg <= '0; emt_reg <= '0;
            rcol_reg <= '0; rrow_reg <= '0;
            ecol_reg <= '0; erow_reg <= '0;
            wp_reg <= '0; cp_reg <= '0;
            s1_shift_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            rcv_reg <= rcv_next; emt_reg <= emt_next;
            rcol_reg <= rcol_next; rrow_reg <= rrow_next;
            ecol_reg <= ecol_next; erow_reg <= erow_next;
            wp_reg <= wp_next; cp_reg <= cp_next;
            s1_shift_reg <= shift;
            s1_res_reg   <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            if (is_data)
            begin
                vmem[wp_reg] <= s_tdata[31:0];
                cmem[cp_reg] <= s_tdata[191:32];
            end
            rd_a_reg <= vmem[ra];
            rd_u_reg <= vmem[ru];
            rd_c_reg <= cmem[rc];
            cur_reg  <= is_data ? s_tdata[31:0] : '0;
            s1_last_reg <= last_p;
            s1_en_reg   <= {pcol != '0, pcol != w - 9'd1, prow != '0, prow != h - 9'd1};
        end
        if (s1_shift_reg)
        begin
            win_l_reg <= win_m_reg;
            win_m_reg <= rd_a_reg;
        end
    end

    assign q_push = s1_res_reg;

    // neighbours off the grid may come from entries not yet written: zero both factors
    always_comb
    begin
        q_entry.val_c = win_m_reg;
        q_entry.val_l = s1_en_reg[3] ? win_l_reg : '0;
        q_entry.val_r = s1_en_reg[2] ? rd_a_reg  : '0;
        q_entry.val_u = s1_en_reg[1] ? rd_u_reg  : '0;
        q_entry.val_d = s1_en_reg[0] ? cur_reg   : '0;
        q_entry.co_c  = rd_c_reg[31:0];
        q_entry.co_l  = s1_en_reg[3] ? rd_c_reg[63:32]   : '0;
        q_entry.co_r  = s1_en_reg[2] ? rd_c_reg[95:64]   : '0;
        q_entry.co_u  = s1_en_reg[1] ? rd_c_reg[127:96]  : '0;
        q_entry.co_d  = s1_en_reg[0] ? rd_c_reg[159:128] : '0;
        q_entry.last  = s1_last_reg;
    end

endmodule
`default_nettype wire

// ----- hdl/fsp_queue.sv -----
// Short job queue between front and back end.
// Depends on fsp_pkg.
`default_nettype none
module fsp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  fsp_pkg::job_t      wr_job,
    input  wire logic          pop,
    output fsp_pkg::job_t      rd_job,
    output logic               not_empty,
    output logic [fsp_pkg::QCNT_W-1:0] fill
);
    import fsp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    job_t              slot_reg [QDEPTH];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= wr_job;
    end

    assign rd_job    = slot_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign fill      = cnt_reg;

endmodule
`default_nettype wire

// ----- hdl/fsp_back.sv -----
// Back end: five products, two adder stages, rounding, saturation, output register.
// Depends on fsp_pkg.
`default_nettype none
module fsp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  fsp_pkg::job_t      job,
    input  wire logic          job_valid,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);
    import fsp_pkg::*;

    logic p_v_reg, a_v_reg, b_v_reg, o_v_reg;
    logic p_last_reg, a_last_reg, b_last_reg;
    logic en_p, en_a, en_b, en_o;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [64:0] a0_reg, a1_reg, a2_reg;
    logic signed [66:0] sum_reg;
    logic signed [50:0] rnd;
    logic [47:0]        res;
    logic               sat;

    assign en_o = !o_v_reg || m_tready;
    assign en_b = !b_v_reg || en_o;
    assign en_a = !a_v_reg || en_b;
    assign en_p = !p_v_reg || en_a;
    assign pop  = job_valid && en_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (en_p) p_v_reg <= pop;
            if (en_a) a_v_reg <= p_v_reg;
            if (en_b) b_v_reg <= a_v_reg;
            if (en_o) o_v_reg <= b_v_reg;
        end
    end

    always_comb
    begin
        rnd = sum_reg[66:16];
        sat = 1'b0;
        res = rnd[47:0];
        if (!rnd[50] && (rnd[49:47] != 3'b000))
        begin
            sat = 1'b1;
            res = {1'b0, {47{1'b1}}};
        end
        else if (rnd[50] && (rnd[49:47] != 3'b111))
        begin
            sat = 1'b1;
            res = {1'b1, {47{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_p)
        begin
            p0_reg <= job.co_c * job.val_c;
            p1_reg <= job.co_l * job.val_l;
            p2_reg <= job.co_r * job.val_r;
            p3_reg <= job.co_u * job.val_u;
            p4_reg <= job.co_d * job.val_d;
            p_last_reg <= job.last;
        end
        if (en_a)
        begin
            a0_reg <= 65'(p0_reg) + 65'(p1_reg);
            a1_reg <= 65'(p2_reg) + 65'(p3_reg);
            a2_reg <= 65'(p4_reg) + 65'(HALF_LSB);
            a_last_reg <= p_last_reg;
        end
        if (en_b)
        begin
            sum_reg <= 67'(a0_reg) + 67'(a1_reg) + 67'(a2_reg);
            b_last_reg <= a_last_reg;
        end
        if (en_o)
        begin
            m_tdata <= res;
            m_tuser <= sat;
            m_tlast <= b_last_reg;
        end
    end

    assign m_tvalid = o_v_reg;

endmodule
`default_nettype wire
